// ----- rtl/bfm_pkg.sv -----
// Shared types and constants of the Bloom filter membership core.
package bfm_pkg;

    localparam int HASH_W = 64;
    localparam int BITS_W = 17;
    localparam int PROBES_W = 5;
    localparam int DIV_STEP = 4;
    localparam int DIV_ITERS = HASH_W / DIV_STEP;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [HASH_W-1:0] h1;
        logic [HASH_W-1:0] h2;
    } t_job;

endpackage

// ----- rtl/bfm_ram.sv -----
// Generic single-port RAM with registered read data.
module bfm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bfm_front.sv -----
// Front end: hashes key bytes and hands finished keys and clears to the queue.
module bfm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_key_byte,
    input  logic          i_key_end,
    input  logic          i_no_byte,
    output logic          o_push,
    output bfm_pkg::t_job o_job
);

    logic [bfm_pkg::HASH_W-1:0] r_fnv;
    logic [bfm_pkg::HASH_W-1:0] r_poly;
    logic [bfm_pkg::HASH_W-1:0] n_fnv;
    logic [bfm_pkg::HASH_W-1:0] n_poly;
    logic [bfm_pkg::HASH_W-1:0] x;

    // Multiplication by the FNV prime, which is 2^40 + 0x1B3.
    function automatic logic [bfm_pkg::HASH_W-1:0] fnv_mul(
        input logic [bfm_pkg::HASH_W-1:0] v
    );
        return (v << 40) + (v << 8) + (v << 7) + (v << 5) + (v << 4) + (v << 1) + v;
    endfunction

    always_comb begin
        x = r_fnv ^ {56'd0, i_key_byte};
        if (i_no_byte) begin
            n_fnv  = r_fnv;
            n_poly = r_poly;
        end else begin
            n_fnv  = fnv_mul(x);
            n_poly = (r_poly << 5) - r_poly + {56'd0, i_key_byte};
        end
    end

    assign o_push = i_accept && ((i_kind == bfm_pkg::KIND_CLEAR) ||
                    ((i_kind != bfm_pkg::KIND_NONE) && i_key_end));
    assign o_job.kind = i_kind;
    assign o_job.h1   = n_fnv;
    assign o_job.h2   = n_poly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fnv  <= bfm_pkg::FNV_BASIS;
            r_poly <= '0;
        end else if (i_accept && i_kind != bfm_pkg::KIND_NONE) begin
            if (i_kind == bfm_pkg::KIND_CLEAR || i_key_end) begin
                r_fnv  <= bfm_pkg::FNV_BASIS;
                r_poly <= '0;
            end else begin
                r_fnv  <= n_fnv;
                r_poly <= n_poly;
            end
        end
    end

endmodule

// ----- rtl/bfm_queue.sv -----
// Two-entry queue of jobs between the hashing front end and the probe engine.
module bfm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bfm_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_valid,
    output logic          o_full,
    output bfm_pkg::t_job o_job
);

    localparam int PW = $clog2(bfm_pkg::QUEUE_DEPTH);

    bfm_pkg::t_job r_slot [bfm_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PW+1)'(bfm_pkg::QUEUE_DEPTH));
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(bfm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(bfm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/bfm_back.sv -----
// Probe engine: modulo reduction, bit store access, clearing and result register.
module bfm_back #(
    parameter int MAX_BITS = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bfm_pkg::BITS_W-1:0]    i_bit_count,
    input  logic [bfm_pkg::PROBES_W-1:0]  i_probe_count,
    input  logic                          i_job_valid,
    input  bfm_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_init_busy,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_out_kind,
    output logic                          o_out_hit
);

    localparam int AW = $clog2(MAX_BITS);
    localparam int KW = $clog2(MAX_PROBES + 1);
    localparam int NW = bfm_pkg::BITS_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CLEAR, ST_DIV, ST_ACCESS, ST_WAIT, ST_EMIT
    } t_state;

    t_state                     r_state;
    logic                       r_init;
    logic [AW-1:0]              r_clr_addr;
    bfm_pkg::t_job              r_job;
    logic [NW-1:0]              r_n;
    logic [KW-1:0]              r_k;
    logic [KW-1:0]              r_idx;
    logic [bfm_pkg::HASH_W-1:0] r_val;
    logic [bfm_pkg::HASH_W-1:0] r_dividend;
    logic [NW-1:0]              r_rem;
    logic [bfm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                       r_hit;
    logic                       r_out_valid;
    logic [1:0]                 r_out_kind;
    logic                       r_out_hit;

    logic [NW-1:0] n_bits;
    logic [KW-1:0] n_probes;
    logic [NW-1:0] n_rem;
    logic [NW:0]   sh;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic          ram_wdata;
    logic          ram_rdata;
    logic          last_probe;

    // Effective sizes, saturated at the store and probe limits.
    always_comb begin
        if (32'(i_bit_count) > MAX_BITS) begin
            n_bits = NW'(MAX_BITS);
        end else begin
            n_bits = i_bit_count;
        end
        if (32'(i_probe_count) > MAX_PROBES) begin
            n_probes = KW'(MAX_PROBES);
        end else begin
            n_probes = KW'(i_probe_count);
        end
    end

    // Restoring remainder, DIV_STEP dividend bits per cycle.
    always_comb begin
        n_rem = r_rem;
        sh    = '0;
        for (int j = 0; j < bfm_pkg::DIV_STEP; j++) begin
            sh = {n_rem, r_dividend[bfm_pkg::HASH_W-1-j]};
            if (sh >= {1'b0, r_n}) begin
                sh = sh - {1'b0, r_n};
            end
            n_rem = sh[NW-1:0];
        end
    end

    assign last_probe = (KW'(r_idx + 1'b1) == r_k);
    assign ram_addr   = (r_state == ST_CLEAR) ? r_clr_addr : AW'(r_rem);
    assign ram_we     = (r_state == ST_CLEAR) ||
                        (r_state == ST_ACCESS && r_job.kind == bfm_pkg::KIND_INSERT);
    assign ram_wdata  = (r_state != ST_CLEAR);
    assign o_pop      = (r_state == ST_IDLE) && !r_init && i_job_valid;

    bfm_ram #(.WIDTH(1), .DEPTH(MAX_BITS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_init      <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the emit state an accepted result is replaced by the new one.
            if (r_out_valid && i_out_ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (r_init) begin
                        r_state <= ST_CLEAR;
                    end else if (i_job_valid) begin
                        r_job <= i_job;
                        r_n   <= n_bits;
                        r_k   <= n_probes;
                        r_idx <= '0;
                        r_val <= i_job.h1;
                        if (i_job.kind == bfm_pkg::KIND_CLEAR) begin
                            r_hit   <= 1'b0;
                            r_state <= ST_CLEAR;
                        end else if (n_bits == '0 || n_probes == '0) begin
                            r_hit   <= (n_bits != '0);
                            r_state <= ST_EMIT;
                        end else begin
                            r_hit      <= 1'b1;
                            r_dividend <= i_job.h1;
                            r_rem      <= '0;
                            r_cnt      <= '0;
                            r_state    <= ST_DIV;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (r_clr_addr == AW'(MAX_BITS - 1)) begin
                        r_clr_addr <= '0;
                        if (r_init) begin
                            r_init  <= 1'b0;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                ST_DIV: begin
                    r_rem      <= n_rem;
                    r_dividend <= r_dividend << bfm_pkg::DIV_STEP;
                    r_cnt      <= r_cnt + 1'b1;
                    if (r_cnt == bfm_pkg::DIV_CNT_W'(bfm_pkg::DIV_ITERS - 1)) begin
                        r_state <= ST_ACCESS;
                    end
                end
                ST_ACCESS: begin
                    if (r_job.kind == bfm_pkg::KIND_QUERY) begin
                        r_state <= ST_WAIT;
                    end else if (last_probe) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx      <= KW'(r_idx + 1'b1);
                        r_val      <= r_val + r_job.h2;
                        r_dividend <= r_val + r_job.h2;
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_state    <= ST_DIV;
                    end
                end
                ST_WAIT: begin
                    r_hit <= r_hit & ram_rdata;
                    if (last_probe) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_idx      <= KW'(r_idx + 1'b1);
                        r_val      <= r_val + r_job.h2;
                        r_dividend <= r_val + r_job.h2;
                        r_rem      <= '0;
                        r_cnt      <= '0;
                        r_state    <= ST_DIV;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= r_job.kind;
                        r_out_hit   <= r_hit && (r_job.kind == bfm_pkg::KIND_QUERY);
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_init_busy = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_hit   = r_out_hit;

endmodule

// ----- rtl/bloom_filter_membership_core.sv -----
// Top level of the Bloom filter membership core with double hashing.
//
//  Channel      Direction  Contents
//  s_axis       in         tdata[7:0] key byte, tdata[8] no byte, tlast key end,
//                          tuser kind (insert, query, clear)
//  m_axis       out        tdata[0] maybe present, tuser finished kind
//  APB          in/out     0x0 bit count, 0x4 probe count
//
// A key byte is hashed in the cycle it is accepted, so keys stream in at one
// byte per cycle while the queue has room. Each probe of a finished key runs
// through the remainder unit, which retires four dividend bits per cycle, then
// the bit store access, and for a query a wait for the read data. A clear
// sweeps the bit store, one bit per cycle. After reset the same sweep runs and
// no request is accepted until it ends; configuration writes are taken
// throughout. Input and output stall apart: the two-entry job queue and the
// result register decouple them.
module bloom_filter_membership_core #(
    parameter int MAX_BITS = 65536,
    parameter int MAX_PROBES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // key_byte [7:0], no_byte [8], zero fill
    input  logic [1:0]  s_axis_tuser,   // kind [1:0]
    input  logic        s_axis_tlast,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // maybe_present [0], zero fill
    output logic [1:0]  m_axis_tuser,   // done_kind [1:0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [bfm_pkg::BITS_W-1:0]   r_bit_count;
    logic [bfm_pkg::PROBES_W-1:0] r_probe_count;

    logic          in_accept;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    logic          q_full;
    logic          init_busy;
    bfm_pkg::t_job push_job;
    bfm_pkg::t_job pop_job;
    logic          out_hit;

    // Registers are picked by the word address; the low address bits are ignored.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {27'd0, r_probe_count} : {15'd0, r_bit_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count   <= '0;
            r_probe_count <= bfm_pkg::PROBES_W'(1);
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                r_probe_count <= pwdata[bfm_pkg::PROBES_W-1:0];
            end else begin
                r_bit_count <= pwdata[bfm_pkg::BITS_W-1:0];
            end
        end
    end

    // Requests are refused while the queue is full or the store is being swept
    // after reset.
    assign s_axis_tready = !q_full && !init_busy;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    bfm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_kind     (s_axis_tuser),
        .i_key_byte (s_axis_tdata[7:0]),
        .i_key_end  (s_axis_tlast),
        .i_no_byte  (s_axis_tdata[8]),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    bfm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_job   (pop_job)
    );

    bfm_back #(.MAX_BITS(MAX_BITS), .MAX_PROBES(MAX_PROBES)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_bit_count   (r_bit_count),
        .i_probe_count (r_probe_count),
        .i_job_valid   (q_valid),
        .i_job         (pop_job),
        .o_pop         (q_pop),
        .o_init_busy   (init_busy),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_kind    (m_axis_tuser),
        .o_out_hit     (out_hit)
    );

    assign m_axis_tdata = {7'd0, out_hit};

    // The queue is never written while it holds two jobs.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job queue written while full");

    // No request enters while the store is swept after reset.
    a_init_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !s_axis_tready)
        else $error("request accepted during reset sweep");

    // Only a query can report a possible hit.
    a_hit_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tuser == bfm_pkg::KIND_QUERY))
        else $error("hit reported for a non-query result");

    // Results never carry the unused kind.
    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != bfm_pkg::KIND_NONE))
        else $error("result with unused kind");

endmodule
